/* hdl/assert_macros.svh */
// Assertion macros shared by the load/store core RTL.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every clock edge outside reset.
`define LSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property at every clock edge, reset included.
`define LSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LSC_ASSERT(label, prop, msg)
`define LSC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* hdl/lsc_pkg.sv */
// Shared types and constants of the load/store core.
// Depends on nothing; used by the sequencer and the top level.
`default_nettype none
package lsc_pkg;

  // Memory depth is a power of two; addresses are masked to MEM_AW bits.
  localparam int MEM_AW    = 16;
  localparam int MEM_DEPTH = 1 << MEM_AW;

  localparam logic [1:0] CMD_EXEC  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] SP_RESET = 8'hFD;
  localparam logic [7:0] FLAG_Z   = 8'h02;
  localparam logic [7:0] FLAG_N   = 8'h80;

  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDA_ZP  = 8'hA5;
  localparam logic [7:0] OP_LDA_ABS = 8'hAD;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_LDX_ZP  = 8'hA6;
  localparam logic [7:0] OP_LDX_ABS = 8'hAE;
  localparam logic [7:0] OP_LDY_IMM = 8'hA0;
  localparam logic [7:0] OP_LDY_ZP  = 8'hA4;
  localparam logic [7:0] OP_LDY_ABS = 8'hAC;
  localparam logic [7:0] OP_STA_ZP  = 8'h85;
  localparam logic [7:0] OP_STA_ABS = 8'h8D;
  localparam logic [7:0] OP_TAX     = 8'hAA;
  localparam logic [7:0] OP_TAY     = 8'hA8;
  localparam logic [7:0] OP_TXA     = 8'h8A;
  localparam logic [7:0] OP_TYA     = 8'h98;
  localparam logic [7:0] OP_TSX     = 8'hBA;
  localparam logic [7:0] OP_TXS     = 8'h9A;
  localparam logic [7:0] OP_INX     = 8'hE8;
  localparam logic [7:0] OP_INY     = 8'hC8;
  localparam logic [7:0] OP_DEX     = 8'hCA;
  localparam logic [7:0] OP_DEY     = 8'h88;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] mem_address;
    logic [7:0]  mem_data;
  } lsc_cmd_t;

  typedef struct packed {
    logic        bad_opcode;
    logic [7:0]  read_byte;
    logic [15:0] prog_counter;
    logic [7:0]  status_flags;
    logic [7:0]  stack_ptr;
    logic [7:0]  reg_y;
    logic [7:0]  reg_x;
    logic [7:0]  reg_a;
  } lsc_res_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        wdata;
  } lsc_mem_req_t;

  typedef struct packed {
    logic cmd_take;
    logic res_vld;
    logic clearing;
  } lsc_ctl_t;

endpackage
`default_nettype wire

/* hdl/cpu_load_store_transfer_core_top.sv */
// Top level of the load/store core: input buffer, sequencer, memory, output register.
// Depends on lsc_pkg, lsc_ram, lsc_seq and assert_macros.svh.
//
// Usage:
//   Each transfer on the in_ channel carries one command: execute the instruction
//   at the program counter, write one memory byte, or read one memory byte.
//   Each command gives exactly one transfer on the out_ channel with the
//   register file after the command, the byte read (read command) and the
//   undefined-opcode flag.
//   One access a cycle to a single-port memory; the buffer refills only once the
//   sequencer takes its command, and the sequencer takes a new command only
//   once it has finished the last one.
//   Reset clears the architectural registers (stack pointer to 0xFD) and then
//   sweeps all MEM_DEPTH (65536) bytes of the memory to zero, one byte a cycle,
//   with in_tready low throughout.
//   When the receiver stalls, the result holds in the output register; one
//   more finished result waits inside the sequencer, and the buffer holds a
//   third command before in_tready drops.
`default_nettype none
`include "assert_macros.svh"
module cpu_load_store_transfer_core_top
  import lsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [1:0] command, [17:2] mem_address, [25:18] mem_data, [31:26] zero
  input  wire logic [31:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [7:0] reg_a, [15:8] reg_x, [23:16] reg_y, [31:24] stack_ptr,
  // [39:32] status_flags, [55:40] prog_counter, [63:56] read_byte,
  // [64] bad_opcode, [71:65] zero
  output logic      [71:0] out_tdata
);

  logic         buf_vld_r;
  lsc_cmd_t     buf_r;
  logic         out_vld_r;
  lsc_res_t     out_r;
  logic         out_free;
  lsc_mem_req_t mem_req;
  logic [7:0]   mem_rdata;
  lsc_res_t     res;
  lsc_ctl_t     ctl;

  // Hold off commands while the buffer is full or the memory is being cleared.
  assign in_tready = !buf_vld_r && !ctl.clearing;
  assign out_free  = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      buf_vld_r <= 1'b1;
    end else if (ctl.cmd_take) begin
      buf_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      buf_r.command     <= in_tdata[1:0];
      buf_r.mem_address <= in_tdata[17:2];
      buf_r.mem_data    <= in_tdata[25:18];
    end
  end

  lsc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_vld  (buf_vld_r),
    .cmd      (buf_r),
    .out_free (out_free),
    .mem_rdata(mem_rdata),
    .mem_req  (mem_req),
    .res      (res),
    .ctl      (ctl)
  );

  lsc_ram #(
    .WIDTH(8),
    .DEPTH(MEM_DEPTH)
  ) u_mem (
    .clk  (clk),
    .en   (mem_req.en),
    .we   (mem_req.we),
    .addr (mem_req.addr),
    .wdata(mem_req.wdata),
    .rdata(mem_rdata)
  );

  // Load a finished result; drop valid once the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ctl.res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_vld) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'b0, out_r};

  `LSC_ASSERT(a_res_into_free, ctl.res_vld |-> (!out_vld_r || out_tready), "output overrun")
  `LSC_ASSERT(a_take_buffered, ctl.cmd_take |-> buf_vld_r, "command taken from empty buffer")
  `LSC_ASSERT_ALWAYS(a_clear_after_rst, !rst_n |=> !in_tready, "input ready during memory clear")

endmodule
`default_nettype wire

/* hdl/lsc_ram.sv */
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none
module lsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/lsc_seq.sv */
// Instruction sequencer and architectural registers of the load/store core.
// Depends on lsc_pkg; drives the shared byte memory, at most one access per cycle.
`default_nettype none
module lsc_seq
  import lsc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cmd_vld,
  input  wire lsc_cmd_t     cmd,
  input  wire logic         out_free,
  input  wire logic [7:0]   mem_rdata,
  output lsc_mem_req_t      mem_req,
  output lsc_res_t          res,
  output lsc_ctl_t          ctl
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DEC, S_ZP, S_LO, S_HI, S_LOAD, S_RD, S_WAIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [MEM_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [7:0]        a_r, a_nxt, x_r, x_nxt, y_r, y_nxt;
  logic [7:0]        sp_r, sp_nxt, p_r, p_nxt;
  logic [15:0]       pc_r, pc_nxt;
  logic [7:0]        op_r, op_nxt, lo_r, lo_nxt;
  logic [7:0]        rd_r, rd_nxt;
  logic              bad_r, bad_nxt;
  logic              fin;

  function automatic logic [7:0] zn(input logic [7:0] f, input logic [7:0] v);
    return (f & ~(FLAG_Z | FLAG_N)) | ((v == 8'h00) ? FLAG_Z : 8'h00) | (v & FLAG_N);
  endfunction

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    a_nxt = a_r; x_nxt = x_r; y_nxt = y_r;
    sp_nxt = sp_r; p_nxt = p_r; pc_nxt = pc_r;
    op_nxt = op_r; lo_nxt = lo_r;
    rd_nxt = 8'h00; bad_nxt = 1'b0;
    fin = 1'b0;
    mem_req = '0;
    ctl = '0;

    unique case (state_r)
      S_CLR: begin
        ctl.clearing = 1'b1;
        mem_req.en   = 1'b1;
        mem_req.we   = 1'b1;
        mem_req.addr = clr_addr_r;
        clr_addr_nxt = clr_addr_r + MEM_AW'(1);
        if (&clr_addr_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_vld) begin
          ctl.cmd_take = 1'b1;
          unique case (cmd.command)
            CMD_EXEC: begin
              mem_req.en   = 1'b1;
              mem_req.addr = pc_r[MEM_AW-1:0];
              pc_nxt       = pc_r + 16'd1;
              state_nxt    = S_DEC;
            end
            CMD_WRITE: begin
              mem_req.en    = 1'b1;
              mem_req.we    = 1'b1;
              mem_req.addr  = cmd.mem_address[MEM_AW-1:0];
              mem_req.wdata = cmd.mem_data;
              fin           = 1'b1;
            end
            CMD_READ: begin
              mem_req.en   = 1'b1;
              mem_req.addr = cmd.mem_address[MEM_AW-1:0];
              state_nxt    = S_RD;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_DEC: begin
        op_nxt = mem_rdata;
        unique case (mem_rdata)
          OP_LDA_IMM, OP_LDX_IMM, OP_LDY_IMM: begin
            mem_req.en   = 1'b1;
            mem_req.addr = pc_r[MEM_AW-1:0];
            pc_nxt       = pc_r + 16'd1;
            state_nxt    = S_LOAD;
          end
          OP_LDA_ZP, OP_LDX_ZP, OP_LDY_ZP, OP_STA_ZP: begin
            mem_req.en   = 1'b1;
            mem_req.addr = pc_r[MEM_AW-1:0];
            pc_nxt       = pc_r + 16'd1;
            state_nxt    = S_ZP;
          end
          OP_LDA_ABS, OP_LDX_ABS, OP_LDY_ABS, OP_STA_ABS: begin
            mem_req.en   = 1'b1;
            mem_req.addr = pc_r[MEM_AW-1:0];
            pc_nxt       = pc_r + 16'd1;
            state_nxt    = S_LO;
          end
          OP_TAX: begin x_nxt = a_r; p_nxt = zn(p_r, a_r); fin = 1'b1; end
          OP_TAY: begin y_nxt = a_r; p_nxt = zn(p_r, a_r); fin = 1'b1; end
          OP_TXA: begin a_nxt = x_r; p_nxt = zn(p_r, x_r); fin = 1'b1; end
          OP_TYA: begin a_nxt = y_r; p_nxt = zn(p_r, y_r); fin = 1'b1; end
          OP_TSX: begin x_nxt = sp_r; p_nxt = zn(p_r, sp_r); fin = 1'b1; end
          OP_TXS: begin sp_nxt = x_r; fin = 1'b1; end
          OP_INX: begin
            x_nxt = x_r + 8'd1; p_nxt = zn(p_r, x_r + 8'd1); fin = 1'b1;
          end
          OP_INY: begin
            y_nxt = y_r + 8'd1; p_nxt = zn(p_r, y_r + 8'd1); fin = 1'b1;
          end
          OP_DEX: begin
            x_nxt = x_r - 8'd1; p_nxt = zn(p_r, x_r - 8'd1); fin = 1'b1;
          end
          OP_DEY: begin
            y_nxt = y_r - 8'd1; p_nxt = zn(p_r, y_r - 8'd1); fin = 1'b1;
          end
          default: begin bad_nxt = 1'b1; fin = 1'b1; end
        endcase
      end
      S_ZP: begin
        mem_req.en   = 1'b1;
        mem_req.addr = MEM_AW'({8'h00, mem_rdata});
        if (op_r == OP_STA_ZP) begin
          mem_req.we    = 1'b1;
          mem_req.wdata = a_r;
          fin           = 1'b1;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_LO: begin
        lo_nxt       = mem_rdata;
        mem_req.en   = 1'b1;
        mem_req.addr = pc_r[MEM_AW-1:0];
        pc_nxt       = pc_r + 16'd1;
        state_nxt    = S_HI;
      end
      S_HI: begin
        mem_req.en   = 1'b1;
        mem_req.addr = MEM_AW'({mem_rdata, lo_r});
        if (op_r == OP_STA_ABS) begin
          mem_req.we    = 1'b1;
          mem_req.wdata = a_r;
          fin           = 1'b1;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        fin = 1'b1;
        unique case (op_r)
          OP_LDA_IMM, OP_LDA_ZP, OP_LDA_ABS: begin
            a_nxt = mem_rdata; p_nxt = zn(p_r, mem_rdata);
          end
          OP_LDX_IMM, OP_LDX_ZP, OP_LDX_ABS: begin
            x_nxt = mem_rdata; p_nxt = zn(p_r, mem_rdata);
          end
          OP_LDY_IMM, OP_LDY_ZP, OP_LDY_ABS: begin
            y_nxt = mem_rdata; p_nxt = zn(p_r, mem_rdata);
          end
          default: ;
        endcase
      end
      S_RD: begin
        rd_nxt = mem_rdata;
        fin    = 1'b1;
      end
      S_WAIT: begin
        rd_nxt  = rd_r;
        bad_nxt = bad_r;
        fin     = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase

    // Deliver the result now if the output register is free, else hold it.
    if (fin) begin
      if (out_free) begin
        ctl.res_vld = 1'b1;
        state_nxt   = S_IDLE;
      end else begin
        state_nxt = S_WAIT;
      end
    end

    res.reg_a        = a_nxt;
    res.reg_x        = x_nxt;
    res.reg_y        = y_nxt;
    res.stack_ptr    = sp_nxt;
    res.status_flags = p_nxt;
    res.prog_counter = pc_nxt;
    res.read_byte    = rd_nxt;
    res.bad_opcode   = bad_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_addr_r <= '0;
      a_r        <= 8'h00;
      x_r        <= 8'h00;
      y_r        <= 8'h00;
      sp_r       <= SP_RESET;
      p_r        <= 8'h00;
      pc_r       <= 16'h0000;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      a_r        <= a_nxt;
      x_r        <= x_nxt;
      y_r        <= y_nxt;
      sp_r       <= sp_nxt;
      p_r        <= p_nxt;
      pc_r       <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    lo_r  <= lo_nxt;
    rd_r  <= rd_nxt;
    bad_r <= bad_nxt;
  end

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the load/store core: a clocked stream driver and monitor,
// with a cycle-free register and memory predictor. Depends on lsc_pkg and the core top.
`timescale 1ns / 100ps
module tb_top;
  import lsc_pkg::*;

  // Command code the core leaves unused
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum int {MODE_NONE, MODE_IMM, MODE_ZP, MODE_ABS} amode_t;

  localparam bit [7:0] OP_SET [21] = '{
    OP_LDA_IMM, OP_LDA_ZP, OP_LDA_ABS, OP_LDX_IMM, OP_LDX_ZP, OP_LDX_ABS,
    OP_LDY_IMM, OP_LDY_ZP, OP_LDY_ABS, OP_STA_ZP, OP_STA_ABS, OP_TAX, OP_TAY,
    OP_TXA, OP_TYA, OP_TSX, OP_TXS, OP_INX, OP_INY, OP_DEX, OP_DEY};

  // Clock and reset
  logic clk;
  logic rst_n = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stream ports; every input starts from a known value
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  // [1:0] command, [17:2] mem_address, [25:18] mem_data, [31:26] zero
  logic [31:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [7:0] reg_a, [15:8] reg_x, [23:16] reg_y, [31:24] stack_ptr,
  // [39:32] status_flags, [55:40] prog_counter, [63:56] read_byte, [64] bad_opcode
  logic [71:0] out_tdata;

  cpu_load_store_transfer_core_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Predicted core state, advanced once per accepted command
  bit [7:0]  cpu_a  = 8'h00;
  bit [7:0]  cpu_x  = 8'h00;
  bit [7:0]  cpu_y  = 8'h00;
  bit [7:0]  cpu_sp = SP_RESET;
  bit [7:0]  cpu_p  = 8'h00;
  bit [15:0] cpu_pc = 16'h0000;
  bit [7:0]  mem_img [0:MEM_DEPTH-1];

  // Commands waiting to be driven, and register snapshots waiting on the output
  lsc_cmd_t cmd_q [$];
  lsc_res_t expected_regs_q [$];
  lsc_cmd_t cur_cmd;

  int n_pushed   = 0;
  int n_accepted = 0;
  int n_errors   = 0;
  int tx_wait    = 0;
  int rx_wait    = 0;
  logic rx_hold  = 1'b0;

  // Stimulus planning: where the next planned instruction starts, and addresses
  // recently written so that loads and reads hit live data
  bit [15:0] plan_pc = 16'h0000;
  bit [15:0] addr_pool [$];
  int        sweep_idx = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic amode_t addr_mode(input bit [7:0] op);
    case (op)
      OP_LDA_IMM, OP_LDX_IMM, OP_LDY_IMM:                        return MODE_IMM;
      OP_LDA_ZP, OP_LDX_ZP, OP_LDY_ZP, OP_STA_ZP:                 return MODE_ZP;
      OP_LDA_ABS, OP_LDX_ABS, OP_LDY_ABS, OP_STA_ABS:             return MODE_ABS;
      default:                                                   return MODE_NONE;
    endcase
  endfunction

  // Fetch the byte at the program counter and advance it, wrapping at 16 bits
  function automatic bit [7:0] fetch_byte();
    bit [7:0] b;
    b = mem_img[cpu_pc];
    cpu_pc = cpu_pc + 16'd1;
    return b;
  endfunction

  // Status byte with Z and N replaced from a value
  function automatic bit [7:0] with_zn(input bit [7:0] v);
    return (cpu_p & ~(FLAG_Z | FLAG_N)) | ((v == 8'h00) ? FLAG_Z : 8'h00) | (v & FLAG_N);
  endfunction

  task automatic run_insn(output bit bad);
    bit [7:0]  op;
    bit [15:0] ea;
    bad = 1'b0;
    ea  = 16'h0000;
    op  = fetch_byte();
    case (addr_mode(op))
      MODE_IMM: begin
        ea = cpu_pc;
        cpu_pc = cpu_pc + 16'd1;
      end
      MODE_ZP: ea = {8'h00, fetch_byte()};
      MODE_ABS: begin
        ea[7:0]  = fetch_byte();
        ea[15:8] = fetch_byte();
      end
      default: ;
    endcase
    case (op)
      OP_LDA_IMM, OP_LDA_ZP, OP_LDA_ABS: begin
        cpu_a = mem_img[ea];
        cpu_p = with_zn(cpu_a);
      end
      OP_LDX_IMM, OP_LDX_ZP, OP_LDX_ABS: begin
        cpu_x = mem_img[ea];
        cpu_p = with_zn(cpu_x);
      end
      OP_LDY_IMM, OP_LDY_ZP, OP_LDY_ABS: begin
        cpu_y = mem_img[ea];
        cpu_p = with_zn(cpu_y);
      end
      OP_STA_ZP, OP_STA_ABS: mem_img[ea] = cpu_a;
      OP_TAX: begin
        cpu_x = cpu_a;
        cpu_p = with_zn(cpu_x);
      end
      OP_TAY: begin
        cpu_y = cpu_a;
        cpu_p = with_zn(cpu_y);
      end
      OP_TXA: begin
        cpu_a = cpu_x;
        cpu_p = with_zn(cpu_a);
      end
      OP_TYA: begin
        cpu_a = cpu_y;
        cpu_p = with_zn(cpu_a);
      end
      OP_TSX: begin
        cpu_x = cpu_sp;
        cpu_p = with_zn(cpu_x);
      end
      OP_TXS: cpu_sp = cpu_x;
      OP_INX: begin
        cpu_x = cpu_x + 8'd1;
        cpu_p = with_zn(cpu_x);
      end
      OP_INY: begin
        cpu_y = cpu_y + 8'd1;
        cpu_p = with_zn(cpu_y);
      end
      OP_DEX: begin
        cpu_x = cpu_x - 8'd1;
        cpu_p = with_zn(cpu_x);
      end
      OP_DEY: begin
        cpu_y = cpu_y - 8'd1;
        cpu_p = with_zn(cpu_y);
      end
      default: bad = 1'b1;
    endcase
  endtask

  // Apply one command to the predicted state and snapshot the registers
  task automatic retire_cmd(input lsc_cmd_t c, output lsc_res_t r);
    bit       bad;
    bit [7:0] rd;
    bad = 1'b0;
    rd  = 8'h00;
    case (c.command)
      CMD_EXEC:  run_insn(bad);
      CMD_WRITE: mem_img[c.mem_address] = c.mem_data;
      CMD_READ:  rd = mem_img[c.mem_address];
      default: ;
    endcase
    r.reg_a        = cpu_a;
    r.reg_x        = cpu_x;
    r.reg_y        = cpu_y;
    r.stack_ptr    = cpu_sp;
    r.status_flags = cpu_p;
    r.prog_counter = cpu_pc;
    r.read_byte    = rd;
    r.bad_opcode   = bad;
  endtask

  // Idle length: mostly none or short, now and then long
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present queued commands, predict each one at its transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : cmd_driver
    lsc_res_t r;
    bit       v_next;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      tx_wait = 0;
    end else begin
      v_next = in_tvalid;
      // Predict before bumping the count, so a waiting planner sees settled state
      if (in_tvalid && in_tready) begin
        retire_cmd(cur_cmd, r);
        expected_regs_q.push_back(r);
        n_accepted++;
        tx_wait = rand_gap();
        v_next = 1'b0;
      end
      // Hold the current command until it transfers; otherwise idle or advance
      if (!v_next) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          in_tdata <= {6'b0, cur_cmd.mem_data, cur_cmd.mem_address, cur_cmd.command};
          v_next = 1'b1;
        end
      end
      in_tvalid <= v_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare every output transfer with the oldest snapshot
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : res_monitor
    lsc_res_t got;
    lsc_res_t want;
    bit       rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[64:0];
        if (expected_regs_q.size() == 0) begin
          $error("output transfer with no command outstanding");
          n_errors++;
        end else begin
          want = expected_regs_q.pop_front();
          check_field("reg_a", want.reg_a, got.reg_a);
          check_field("reg_x", want.reg_x, got.reg_x);
          check_field("reg_y", want.reg_y, got.reg_y);
          check_field("stack_ptr", want.stack_ptr, got.stack_ptr);
          check_field("status_flags", want.status_flags, got.status_flags);
          check_field("prog_counter", want.prog_counter, got.prog_counter);
          check_field("read_byte", want.read_byte, got.read_byte);
          check_field("bad_opcode", want.bad_opcode, got.bad_opcode);
        end
        rx_wait = rand_gap();
      end
      // Stall after some transfers; the pressure process can force a long hold-off
      if (rx_hold) begin
        rdy = 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_tready <= rdy;
    end
  end

  // Hold the receiver off for a long stretch while commands are still queued,
  // so the core fills up and drops in_tready
  initial begin : rx_pressure
    do @(posedge clk); while (!(n_accepted >= 100 && cmd_q.size() >= 4));
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_cmd(input logic [1:0] cmd, input bit [15:0] a, input bit [7:0] d);
    lsc_cmd_t c;
    c.command     = cmd;
    c.mem_address = a;
    c.mem_data    = d;
    cmd_q.push_back(c);
    n_pushed++;
  endtask

  // Wait until every queued command has transferred, so the predicted pc is current
  task automatic settle();
    wait (n_accepted == n_pushed);
  endtask

  // Pause the sender until every expected result has arrived
  task automatic drain();
    settle();
    while (expected_regs_q.size() != 0) @(posedge clk);
  endtask

  task automatic note_addr(input bit [15:0] a);
    addr_pool.push_back(a);
    if (addr_pool.size() > 24) void'(addr_pool.pop_front());
  endtask

  function automatic bit [15:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'h0000;
    if (r < 10) return 16'hFFFF;
    if (r < 60 && addr_pool.size() > 0) return addr_pool[$urandom_range(0, addr_pool.size() - 1)];
    return 16'($urandom_range(0, 65535));
  endfunction

  // Bias data toward zero and negative values so both flags move
  function automatic bit [7:0] pick_data();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 8'h00;
    if (r < 30) return 8'hFF;
    if (r < 40) return 8'h80;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic bit known_op(input bit [7:0] op);
    foreach (OP_SET[i]) if (OP_SET[i] == op) return 1'b1;
    return 1'b0;
  endfunction

  // Sweep the opcode set twice in order, then draw at random with some undefined ones
  function automatic bit [7:0] next_op();
    bit [7:0] op;
    if (sweep_idx < 42) begin
      op = OP_SET[sweep_idx % 21];
      sweep_idx++;
      return op;
    end
    if ($urandom_range(0, 99) < 85) return OP_SET[$urandom_range(0, 20)];
    do op = 8'($urandom_range(0, 255)); while (known_op(op));
    return op;
  endfunction

  // Lay an instruction down at the planned pc and execute it; optionally seed
  // the load target first
  task automatic emit_insn(input bit [7:0] op, input bit [15:0] opnd, input bit seed);
    amode_t    m;
    bit [15:0] tgt;
    m   = addr_mode(op);
    tgt = (m == MODE_ZP) ? {8'h00, opnd[7:0]} : opnd;
    if (op == OP_STA_ZP || op == OP_STA_ABS) begin
      note_addr(tgt);
    end else if (seed && (m == MODE_ZP || m == MODE_ABS) && $urandom_range(0, 99) < 60) begin
      push_cmd(CMD_WRITE, tgt, pick_data());
      note_addr(tgt);
    end
    push_cmd(CMD_WRITE, plan_pc, op);
    if (m != MODE_NONE) push_cmd(CMD_WRITE, plan_pc + 16'd1, opnd[7:0]);
    if (m == MODE_ABS) push_cmd(CMD_WRITE, plan_pc + 16'd2, opnd[15:8]);
    push_cmd(CMD_EXEC, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    plan_pc = plan_pc + ((m == MODE_NONE) ? 16'd1 : (m == MODE_ABS) ? 16'd3 : 16'd2);
  endtask

  task automatic side_cmd();
    int        r;
    bit [15:0] a;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      a = ($urandom_range(0, 1) != 0) ? pick_addr() : 16'($urandom_range(0, 65535));
      push_cmd(CMD_WRITE, a, pick_data());
      note_addr(a);
    end else if (r < 85) begin
      push_cmd(CMD_READ, pick_addr(), 8'($urandom_range(0, 255)));
    end else begin
      push_cmd(CMD_UNUSED, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
    end
  endtask

  function automatic bit [15:0] pick_operand(input bit [7:0] op);
    bit [15:0] a;
    case (addr_mode(op))
      MODE_IMM: return {8'h00, pick_data()};
      MODE_ZP: begin
        a = pick_addr();
        return ($urandom_range(0, 1) != 0) ? {8'h00, a[7:0]} : 16'($urandom_range(0, 255));
      end
      MODE_ABS: return pick_addr();
      default:  return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly chains of well-formed instructions; the rest is loose memory traffic
  // and execution of whatever sits at the pc
  task automatic random_groups(input int n_items);
    int       start;
    int       k;
    int       r;
    bit [7:0] op;
    start = n_pushed;
    while (n_pushed - start < n_items) begin
      settle();
      plan_pc = cpu_pc;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        k = $urandom_range(1, 5);
        repeat (k) begin
          if ($urandom_range(0, 3) == 0) side_cmd();
          op = next_op();
          emit_insn(op, pick_operand(op), 1'b1);
        end
      end else if (r < 85) begin
        repeat ($urandom_range(1, 8)) side_cmd();
      end else begin
        repeat ($urandom_range(1, 4))
          push_cmd(CMD_EXEC, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (rst_n);

    // Directed: cleared memory, the unused command, field extremes, an
    // undefined opcode, the stack and index wrap, Z and N both ways
    push_cmd(CMD_READ, 16'h0000, 8'h00);
    push_cmd(CMD_UNUSED, 16'hFFFF, 8'hFF);
    push_cmd(CMD_WRITE, 16'hFFFF, 8'hFF);
    push_cmd(CMD_READ, 16'hFFFF, 8'h00);
    // Byte 0 is still zero after reset: an undefined opcode
    push_cmd(CMD_EXEC, 16'h0000, 8'h00);
    plan_pc = 16'h0001;
    emit_insn(OP_TSX, 16'h0000, 1'b0);
    emit_insn(OP_INX, 16'h0000, 1'b0);
    emit_insn(OP_INX, 16'h0000, 1'b0);
    emit_insn(OP_INX, 16'h0000, 1'b0);
    emit_insn(OP_DEX, 16'h0000, 1'b0);
    emit_insn(OP_TXS, 16'h0000, 1'b0);
    emit_insn(OP_LDA_IMM, 16'h0000, 1'b0);
    emit_insn(OP_STA_ABS, 16'hFFFF, 1'b0);
    push_cmd(CMD_READ, 16'hFFFF, 8'h00);

    // Let everything come back before the random traffic starts
    drain();

    random_groups(520);

    // Wait for the last results, then keep clocking for anything stray
    drain();
    repeat (20) @(posedge clk);
    if (expected_regs_q.size() != 0) begin
      $error("%0d expected results never arrived", expected_regs_q.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run, memory sweep included
  initial begin : watchdog
    #10ms;
    $display("tb_top: errors");
    $finish;
  end

endmodule
